>>> rtl/core/m6502pd_pkg.sv
// ============================================================================
// m6502pd_pkg
// Shared types and codes of the 6502 instruction predecoder.
// ============================================================================
package m6502pd_pkg;

	// Control-flow classes of a decoded instruction
	localparam logic [2:0] FLOW_FALL   = 3'd0;
	localparam logic [2:0] FLOW_STOP   = 3'd1;
	localparam logic [2:0] FLOW_CALL   = 3'd2;
	localparam logic [2:0] FLOW_JUMP   = 3'd3;
	localparam logic [2:0] FLOW_BRANCH = 3'd4;

	// Instruction lengths
	localparam logic [1:0] LEN_1 = 2'd1;
	localparam logic [1:0] LEN_2 = 2'd2;
	localparam logic [1:0] LEN_3 = 2'd3;

	// Opcodes decoded outside the cc/bbb/aaa grouping
	localparam logic [7:0] OP_BRK     = 8'h00;
	localparam logic [7:0] OP_RTI     = 8'h40;
	localparam logic [7:0] OP_RTS     = 8'h60;
	localparam logic [7:0] OP_JSR     = 8'h20;
	localparam logic [7:0] OP_JMP_ABS = 8'h4C;
	localparam logic [7:0] OP_JMP_IND = 8'h6C;
	localparam logic [7:0] OP_BIT_ZP  = 8'h24;
	localparam logic [7:0] OP_BIT_ABS = 8'h2C;

	// Opcode field values
	localparam logic [1:0] CC_0    = 2'd0;
	localparam logic [1:0] CC_1    = 2'd1;
	localparam logic [1:0] CC_2    = 2'd2;
	localparam logic [2:0] AAA_ST  = 3'd4;   // store row (STA/STX/STY)
	localparam logic [2:0] AAA_LD  = 3'd5;   // load row
	localparam logic [2:0] BBB_0   = 3'd0;
	localparam logic [2:0] BBB_1   = 3'd1;
	localparam logic [2:0] BBB_2   = 3'd2;
	localparam logic [2:0] BBB_3   = 3'd3;
	localparam logic [2:0] BBB_4   = 3'd4;
	localparam logic [2:0] BBB_5   = 3'd5;
	localparam logic [2:0] BBB_6   = 3'd6;
	localparam logic [2:0] BBB_7   = 3'd7;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [7:0]  operand_low;
		logic [7:0]  operand_high;
		logic [15:0] instruction_address;
	} req_t;

	typedef struct packed {
		logic [1:0]  length;
		logic [2:0]  flow_class;
		logic        target_valid;
		logic [15:0] target_address;
		logic        read_valid;
		logic        write_valid;
		logic [15:0] reference_address;
		logic        unrecognized;
	} rsp_t;

endpackage

>>> rtl/core/m6502pd_decode.sv
// ============================================================================
// m6502pd_decode
// Combinational decode of one opcode with its operand bytes and address.
// ============================================================================
module m6502pd_decode (
	input  m6502pd_pkg::req_t req,
	output m6502pd_pkg::rsp_t rsp
);
	import m6502pd_pkg::*;

	logic [1:0]  cc;
	logic [2:0]  bbb;
	logic [2:0]  aaa;
	logic [15:0] abs16;
	logic [15:0] disp;
	logic [15:0] br_tgt;

	assign cc     = req.opcode[1:0];
	assign bbb    = req.opcode[4:2];
	assign aaa    = req.opcode[7:5];
	assign abs16  = {req.operand_high, req.operand_low};
	assign disp   = {{8{req.operand_low[7]}}, req.operand_low};
	assign br_tgt = req.instruction_address + 16'd2 + disp;

	always_comb begin
		logic       special;
		logic       addr;
		logic       bad;
		logic [1:0] len;

		special = 1'b1;
		addr    = 1'b0;
		bad     = 1'b0;
		len     = LEN_1;
		rsp     = '0;
		rsp.length     = LEN_1;
		rsp.flow_class = FLOW_FALL;

		case (req.opcode)
			OP_BRK, OP_RTI, OP_RTS: begin
				rsp.flow_class = FLOW_STOP;
			end
			OP_JSR: begin
				rsp.length         = LEN_3;
				rsp.flow_class     = FLOW_CALL;
				rsp.target_valid   = 1'b1;
				rsp.target_address = abs16;
			end
			OP_JMP_ABS: begin
				rsp.length         = LEN_3;
				rsp.flow_class     = FLOW_JUMP;
				rsp.target_valid   = 1'b1;
				rsp.target_address = abs16;
			end
			OP_JMP_IND: begin
				rsp.length     = LEN_3;
				rsp.flow_class = FLOW_STOP;
			end
			OP_BIT_ZP: begin
				rsp.length            = LEN_2;
				rsp.read_valid        = 1'b1;
				rsp.reference_address = {8'h00, req.operand_low};
			end
			OP_BIT_ABS: begin
				rsp.length            = LEN_3;
				rsp.read_valid        = 1'b1;
				rsp.reference_address = abs16;
			end
			default: begin
				special = 1'b0;
			end
		endcase

		if (!special) begin
			if (cc == CC_0 && (bbb == BBB_2 || bbb == BBB_6)) begin
				// implied single-byte forms (stack, flag, register ops)
				len = LEN_1;
			end else if (cc == CC_2 && bbb == BBB_6 && (aaa == AAA_ST || aaa == AAA_LD)) begin
				// TXS and TSX
				len = LEN_1;
			end else if (cc == CC_0 && bbb == BBB_4) begin
				len                = LEN_2;
				rsp.flow_class     = FLOW_BRANCH;
				rsp.target_valid   = 1'b1;
				rsp.target_address = br_tgt;
			end else if (cc == CC_1) begin
				case (bbb)
					BBB_2:               len = LEN_2;
					BBB_3, BBB_6, BBB_7: begin
						len  = LEN_3;
						addr = 1'b1;
					end
					default: begin
						len  = LEN_2;
						addr = 1'b1;
					end
				endcase
			end else begin
				case (bbb)
					BBB_0:        len = LEN_2;
					BBB_1, BBB_5: begin
						len  = LEN_2;
						addr = 1'b1;
					end
					BBB_3, BBB_7: begin
						len  = LEN_3;
						addr = 1'b1;
					end
					BBB_2: begin
						if (cc == CC_2) begin
							len = LEN_1;
						end else begin
							bad = 1'b1;
						end
					end
					default: bad = 1'b1;
				endcase
			end

			if (bad) begin
				rsp.length       = LEN_1;
				rsp.unrecognized = 1'b1;
			end else begin
				rsp.length = len;
				if (addr) begin
					rsp.read_valid        = (aaa != AAA_ST);
					rsp.write_valid       = (aaa == AAA_ST);
					rsp.reference_address = (len == LEN_3) ? abs16
						: {8'h00, req.operand_low};
				end
			end
		end
	end

endmodule

>>> rtl/core/mos6502_instruction_predecoder.sv
// ============================================================================
// mos6502_instruction_predecoder
// Length, control-flow class, target and memory reference of 6502 opcodes.
// ============================================================================
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  -----------------------------
//   req      in         req_valid / req_stall  opcode, operands, address
//   rsp      out        rsp_valid / rsp_stall  length, flow, target, ref
//
// One request is taken every cycle while req_stall is low. Each result
// moves from the input register to the result register and shows on rsp
// from there. Reset clears both stage valid flags; payload registers are
// not reset. rsp_stall holds the result register; the input register still
// fills, and req_stall rises only when both stages hold a request.
//
module mos6502_instruction_predecoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  m6502pd_pkg::req_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output m6502pd_pkg::rsp_t  rsp
);
	import m6502pd_pkg::*;

	req_t req_s1;
	logic vld_s1;
	rsp_t dec_rsp;
	rsp_t rsp_s2;
	logic vld_s2;
	logic adv_s2;
	logic adv_s1;

	// Advance the result stage when it is empty or its result is being taken
	assign adv_s2 = !vld_s2 || !rsp_stall;
	// Advance the input stage when it is empty or can move forward
	assign adv_s1 = !vld_s1 || adv_s2;

	assign req_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= req_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Capture the incoming request; hold while stalled
	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			req_s1 <= req;
		end
	end

	m6502pd_decode u_decode (
		.req (req_s1),
		.rsp (dec_rsp)
	);

	// Capture the decoded result; hold while the consumer stalls
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			rsp_s2 <= dec_rsp;
		end
	end

	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

endmodule

>>> rtl/core/m6502pd_checker.sv
// ============================================================================
// m6502pd_checker
// Port-level checks of the predecoder, bound to its top level.
// ============================================================================
module m6502pd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input m6502pd_pkg::req_t  req,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input m6502pd_pkg::rsp_t  rsp
);
	import m6502pd_pkg::*;

	// A held result stays valid and unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Back-pressure on requests only when the result side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled with result side free");

	// A target is given exactly for calls, jumps and branches
	a_target: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.target_valid == (rsp.flow_class == FLOW_CALL
			|| rsp.flow_class == FLOW_JUMP || rsp.flow_class == FLOW_BRANCH))
		else $error("target flag does not match flow class");

	// Data bytes are single-byte fall-through with no reference
	a_unrec: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.unrecognized |-> rsp.length == LEN_1
			&& rsp.flow_class == FLOW_FALL && !rsp.read_valid && !rsp.write_valid
			&& rsp.reference_address == 16'h0000)
		else $error("data byte decoded with side effects");

endmodule

bind mos6502_instruction_predecoder m6502pd_checker u_m6502pd_checker (.*);

>>> tb/mos6502_instruction_predecoder_tb.sv
// ============================================================================
// mos6502_instruction_predecoder_tb
// Self-checking bench for the 6502 instruction predecoder. Directed opcodes
// cover the stop, call, jump, branch, store, undocumented and data-byte
// cases at extreme operands. A sweep of all 256 opcodes and random requests
// follow. Each request is decoded in the bench and compared field by field
// with the block's result, under random idling on both sides, one long
// result hold-off and one drain of the pipeline.
// ============================================================================
module mos6502_instruction_predecoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import m6502pd_pkg::*;

	// Opcodes used by name in the directed part
	localparam logic [7:0] OP_BPL      = 8'h10;
	localparam logic [7:0] OP_BMI      = 8'h30;
	localparam logic [7:0] OP_BEQ      = 8'hF0;
	localparam logic [7:0] OP_STA_ZP   = 8'h85;
	localparam logic [7:0] OP_STX_ABS  = 8'h8E;
	localparam logic [7:0] OP_STY_ZP   = 8'h84;
	localparam logic [7:0] OP_STY_ABS  = 8'h8C;
	localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
	localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
	localparam logic [7:0] OP_ASL_A    = 8'h0A;
	localparam logic [7:0] OP_TXS      = 8'h9A;
	localparam logic [7:0] OP_TSX      = 8'hBA;
	localparam logic [7:0] OP_SAX_ZP   = 8'h87;   // undocumented, cc 3 store row
	localparam logic [7:0] OP_ISC_ABSX = 8'hFF;   // undocumented, cc 3 absolute
	localparam logic [7:0] OP_NOP_ABSX = 8'h1C;   // undocumented, cc 0 absolute
	localparam logic [7:0] OP_NOP_IMM  = 8'h80;   // undocumented, cc 0 immediate
	localparam logic [7:0] OP_DATA_12  = 8'h12;   // cc 2, bbb 4
	localparam logic [7:0] OP_DATA_1A  = 8'h1A;   // cc 2, bbb 6
	localparam logic [7:0] OP_DATA_0B  = 8'h0B;   // cc 3, bbb 2

	localparam int unsigned RANDOM_REQUESTS = 930;
	localparam int unsigned HOLDOFF_AT      = 300;  // results seen before the long stall
	localparam int unsigned HOLDOFF_CYCLES  = 64;
	localparam int unsigned DRAIN_AT        = 520;  // requests taken before the drain
	localparam int unsigned CALM_FROM       = 650;  // no idling on either side in here
	localparam int unsigned CALM_TO         = 800;
	localparam int unsigned IDLE_PERCENT    = 19;
	localparam int unsigned MAX_PRINTS      = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	req_t pending_requests[$];
	rsp_t expected_decodes[$];
	int unsigned total_requests = 0;
	int unsigned requests_taken = 0;
	int unsigned results_done = 0;
	int unsigned holdoff_left = 0;
	logic holdoff_done = 1'b0;
	int unsigned failures = 0;

	mos6502_instruction_predecoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// Count every failure, print only the first ones
	task automatic flag_error(input string msg);
		failures++;
		if (failures <= MAX_PRINTS) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	// Decode one request the way the block should: fixed opcodes first, then
	// the branch row, implied rows, and the cc/bbb/aaa address-mode grouping.
	function automatic rsp_t predict_decode(input req_t r);
		logic [1:0]  cc;
		logic [2:0]  bbb;
		logic [2:0]  aaa;
		logic [15:0] abs16;
		logic        addressed;
		rsp_t        d;
		cc = r.opcode[1:0];
		bbb = r.opcode[4:2];
		aaa = r.opcode[7:5];
		abs16 = {r.operand_high, r.operand_low};
		addressed = 1'b0;
		d = '0;
		d.length = LEN_1;
		d.flow_class = FLOW_FALL;
		case (r.opcode)
		OP_BRK, OP_RTI, OP_RTS: begin
			d.flow_class = FLOW_STOP;
		end
		OP_JSR: begin
			d.length = LEN_3;
			d.flow_class = FLOW_CALL;
			d.target_valid = 1'b1;
			d.target_address = abs16;
		end
		OP_JMP_ABS: begin
			d.length = LEN_3;
			d.flow_class = FLOW_JUMP;
			d.target_valid = 1'b1;
			d.target_address = abs16;
		end
		OP_JMP_IND: begin
			// indirect target is unknown here: stop, no reference
			d.length = LEN_3;
			d.flow_class = FLOW_STOP;
		end
		OP_BIT_ZP: begin
			d.length = LEN_2;
			d.read_valid = 1'b1;
			d.reference_address = {8'h00, r.operand_low};
		end
		OP_BIT_ABS: begin
			d.length = LEN_3;
			d.read_valid = 1'b1;
			d.reference_address = abs16;
		end
		default: begin
			if (cc == CC_0 && bbb == BBB_4) begin
				// relative branch, wraps at 64K
				d.length = LEN_2;
				d.flow_class = FLOW_BRANCH;
				d.target_valid = 1'b1;
				d.target_address = r.instruction_address + 16'd2
					+ {{8{r.operand_low[7]}}, r.operand_low};
			end else if (cc == CC_0 && (bbb == BBB_2 || bbb == BBB_6)) begin
				// stack, flag and register instructions: one byte, nothing else
			end else if (cc == CC_2 && bbb == BBB_6 && (aaa == AAA_ST || aaa == AAA_LD)) begin
				// TXS and TSX
			end else if (cc == CC_1) begin
				case (bbb)
				BBB_2: d.length = LEN_2;
				BBB_3, BBB_6, BBB_7: begin
					d.length = LEN_3;
					addressed = 1'b1;
				end
				default: begin
					d.length = LEN_2;
					addressed = 1'b1;
				end
				endcase
			end else begin
				case (bbb)
				BBB_0: d.length = LEN_2;
				BBB_1, BBB_5: begin
					d.length = LEN_2;
					addressed = 1'b1;
				end
				BBB_3, BBB_7: begin
					d.length = LEN_3;
					addressed = 1'b1;
				end
				BBB_2: begin
					// accumulator and implied forms for cc 2, data byte otherwise
					if (cc != CC_2) d.unrecognized = 1'b1;
				end
				default: d.unrecognized = 1'b1;
				endcase
			end
			if (addressed) begin
				d.write_valid = (aaa == AAA_ST);
				d.read_valid = (aaa != AAA_ST);
				d.reference_address = (d.length == LEN_3) ? abs16 : {8'h00, r.operand_low};
			end
		end
		endcase
		return d;
	endfunction

	task automatic add_request(input logic [7:0] op, input logic [7:0] lo,
			input logic [7:0] hi, input logic [15:0] pc);
		req_t r;
		r.opcode = op;
		r.operand_low = lo;
		r.operand_high = hi;
		r.instruction_address = pc;
		pending_requests.push_back(r);
	endtask

	// Lean on the extremes now and then
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
		0: return 8'h00;
		1: return 8'hFF;
		2: return 8'h80;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_address();
		case ($urandom_range(7))
		0: return 16'h0000;
		1: return 16'hFFFF;
		2: return 16'hFFFE - 16'($urandom_range(255));
		default: return 16'($urandom);
		endcase
	endfunction

	// Request driver: advance to the next request once the current one is
	// taken, hold it while stalled, idle at random, and drain once.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		int unsigned taken_now;
		logic        idle;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			taken_now = requests_taken;
			if (req_valid && !req_stall) begin
				expected_decodes.push_back(predict_decode(req));
				taken_now = requests_taken + 1;
				requests_taken <= taken_now;
			end
			if (!req_valid || !req_stall) begin
				if (taken_now >= CALM_FROM && taken_now < CALM_TO) begin
					idle = 1'b0;
				end else begin
					idle = ($urandom_range(99) < IDLE_PERCENT);
				end
				// hold off here until every result so far has come back
				if (taken_now == DRAIN_AT && results_done != taken_now) idle = 1'b1;
				if (!idle && pending_requests.size() != 0) begin
					req_valid <= 1'b1;
					req <= pending_requests.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each accepted result against the oldest
	// prediction, then pick the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin : check_results
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_decodes.size() == 0) begin
					flag_error($sformatf("result %0d arrived with no request outstanding",
						results_done));
				end else begin
					want = expected_decodes.pop_front();
					if (rsp.length !== want.length)
						flag_error($sformatf("result %0d length: got %0d, expected %0d",
							results_done, rsp.length, want.length));
					if (rsp.flow_class !== want.flow_class)
						flag_error($sformatf("result %0d flow_class: got %0d, expected %0d",
							results_done, rsp.flow_class, want.flow_class));
					if (rsp.target_valid !== want.target_valid)
						flag_error($sformatf("result %0d target_valid: got %b, expected %b",
							results_done, rsp.target_valid, want.target_valid));
					if (rsp.target_address !== want.target_address)
						flag_error($sformatf("result %0d target_address: got %h, expected %h",
							results_done, rsp.target_address, want.target_address));
					if (rsp.read_valid !== want.read_valid)
						flag_error($sformatf("result %0d read_valid: got %b, expected %b",
							results_done, rsp.read_valid, want.read_valid));
					if (rsp.write_valid !== want.write_valid)
						flag_error($sformatf("result %0d write_valid: got %b, expected %b",
							results_done, rsp.write_valid, want.write_valid));
					if (rsp.reference_address !== want.reference_address)
						flag_error($sformatf("result %0d reference_address: got %h, expected %h",
							results_done, rsp.reference_address, want.reference_address));
					if (rsp.unrecognized !== want.unrecognized)
						flag_error($sformatf("result %0d unrecognized: got %b, expected %b",
							results_done, rsp.unrecognized, want.unrecognized));
				end
				results_done <= results_done + 1;
			end
			// one long hold-off lets both stages fill and back up the requests
			if (holdoff_left != 0) begin
				rsp_stall <= 1'b1;
				holdoff_left <= holdoff_left - 1;
			end else if (!holdoff_done && results_done == HOLDOFF_AT) begin
				rsp_stall <= 1'b1;
				holdoff_left <= HOLDOFF_CYCLES;
				holdoff_done <= 1'b1;
			end else if (results_done >= CALM_FROM && results_done < CALM_TO) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		// stop class, calls, jumps and BIT reads at extreme operands
		add_request(OP_BRK, 8'hFF, 8'hFF, 16'hFFFF);
		add_request(OP_RTI, 8'h00, 8'h00, 16'h0000);
		add_request(OP_RTS, 8'hA5, 8'h5A, 16'h8000);
		add_request(OP_JSR, 8'h00, 8'h00, 16'hFFFF);
		add_request(OP_JSR, 8'hFF, 8'hFF, 16'h0000);
		add_request(OP_JMP_ABS, 8'h34, 8'h12, 16'h4000);
		add_request(OP_JMP_IND, 8'hFF, 8'hFF, 16'hFFFD);
		add_request(OP_BIT_ZP, 8'hFF, 8'hFF, 16'h0200);
		add_request(OP_BIT_ABS, 8'hFF, 8'hFF, 16'h0200);
		// branches: forward wrap past 0xFFFF, backward wrap below zero, self loop
		add_request(OP_BPL, 8'h7F, 8'h00, 16'hFFFF);
		add_request(OP_BMI, 8'h80, 8'hFF, 16'h0000);
		add_request(OP_BEQ, 8'hFE, 8'h00, 16'h1234);
		// store rows write, loads read, immediate and implied forms have no reference
		add_request(OP_STA_ZP, 8'hFF, 8'h00, 16'h0300);
		add_request(OP_STX_ABS, 8'h00, 8'hFF, 16'h0300);
		add_request(OP_STY_ZP, 8'h80, 8'h11, 16'h0300);
		add_request(OP_STY_ABS, 8'hFF, 8'hFF, 16'h0300);
		add_request(OP_LDA_IMM, 8'hFF, 8'hFF, 16'h0300);
		add_request(OP_LDA_ABSX, 8'h01, 8'h80, 16'h0300);
		add_request(OP_ASL_A, 8'hFF, 8'hFF, 16'h0300);
		add_request(OP_TXS, 8'hFF, 8'hFF, 16'h0300);
		add_request(OP_TSX, 8'h00, 8'h00, 16'h0300);
		// undocumented opcodes and data bytes
		add_request(OP_SAX_ZP, 8'hFF, 8'h00, 16'hC000);
		add_request(OP_ISC_ABSX, 8'hFF, 8'hFF, 16'hC000);
		add_request(OP_NOP_ABSX, 8'h00, 8'h80, 16'hC000);
		add_request(OP_NOP_IMM, 8'h7F, 8'h7F, 16'hC000);
		add_request(OP_DATA_12, 8'hFF, 8'hFF, 16'hFFFF);
		add_request(OP_DATA_1A, 8'hFF, 8'hFF, 16'hFFFF);
		add_request(OP_DATA_0B, 8'hFF, 8'hFF, 16'hFFFF);
		// sweep every opcode once, then draw opcodes at random
		for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
			add_request((n < 256) ? 8'(n) : 8'($urandom), pick_byte(), pick_byte(),
				pick_address());
		end
		total_requests = pending_requests.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (results_done != total_requests) @(posedge clk);
		// let any stray result show up
		repeat (8) @(posedge clk);
		if (expected_decodes.size() != 0) begin
			flag_error($sformatf("%0d predictions left without a result",
				expected_decodes.size()));
		end
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#400_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/m6502pd_pkg.sv
rtl/core/m6502pd_decode.sv
rtl/core/mos6502_instruction_predecoder.sv
rtl/core/m6502pd_checker.sv
tb/mos6502_instruction_predecoder_tb.sv
